[rtl/core/deq_pkg.sv]
// Shared types and constants for the double-ended queue core.
// No dependencies; used by deq_cell and double_ended_queue_core.

package deq_pkg;

   localparam int DEQ_DEPTH = 16;
   localparam int WORD_W    = 32;
   localparam int FILL_W    = 5;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Per-cell update controls for one cycle.
   typedef struct packed {
      logic take_front;   // copy the word of the neighbor toward the front
      logic take_rear;    // copy the word of the neighbor toward the rear
      logic load;         // write the incoming beat's value
   } cell_ctrl_type;

endpackage

[rtl/core/deq_cell.sv]
// One storage cell of the queue's shifting row.
// Depends on deq_pkg for the word width and the control struct.

module deq_cell
   import deq_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [WORD_W-1:0] front_word,
   input  logic signed [WORD_W-1:0] rear_word,
   input  logic signed [WORD_W-1:0] value,
   output logic signed [WORD_W-1:0] word
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;

   always_comb begin
      priority if (ctrl.take_front) begin
         word_in = front_word;
      end else if (ctrl.take_rear) begin
         word_in = rear_word;
      end else if (ctrl.load) begin
         word_in = value;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

[rtl/core/double_ended_queue_core.sv]
// Top level of the double-ended queue: a row of deq_cell storage cells with
// the front always in cell 0, plus the count and the result register.
// Depends on deq_pkg and deq_cell.
//
//   channel  ports                                     direction
//   request  start, busy, req_kind, req_value          in (busy out)
//   result   rsp_valid, rsp_data, rsp_status, rsp_fill out, one-cycle strobe
//
// The row of cells shifts or loads at the edge that accepts the beat, and
// the result is shown on the next cycle for one cycle. A beat may be
// accepted in every cycle; busy stays low.
// Reset clears the count and the result strobe; cells need no clearing.
// The receiver cannot stall the result channel.

module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic [1:0]               rsp_status,
   output logic [FILL_W-1:0]        rsp_fill
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0] rsp_fill_ff;

   logic signed [WORD_W-1:0] cell_word [DEPTH];
   cell_ctrl_type            cell_ctrl [DEPTH];
   logic signed [WORD_W-1:0] rear_tap;

   logic     accept;
   kind_type kind;
   logic     is_full, is_empty;
   logic     do_push_front, do_push_rear, do_pop_front, do_pop_rear;
   logic [EXT_W-1:0] count_ext;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign kind     = kind_type'(req_kind);
   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      do_push_front = 1'b0;
      do_push_rear  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_rear   = 1'b0;
      rsp_status_in = ST_OK;
      unique case (kind)
         KIND_PUSH_FRONT: begin
            if (is_full) rsp_status_in = ST_OVERFLOW;
            else         do_push_front = accept;
         end
         KIND_PUSH_REAR: begin
            if (is_full) rsp_status_in = ST_OVERFLOW;
            else         do_push_rear = accept;
         end
         KIND_POP_FRONT: begin
            if (is_empty) rsp_status_in = ST_UNDERFLOW;
            else          do_pop_front = accept;
         end
         KIND_POP_REAR: begin
            if (is_empty) rsp_status_in = ST_UNDERFLOW;
            else          do_pop_rear = accept;
         end
         default: rsp_status_in = ST_OK;
      endcase
   end

   // A front push shifts the row toward the rear; a front pop shifts it
   // toward the front. A rear push loads the first empty cell.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i].take_front = do_push_front;
         cell_ctrl[i].take_rear  = do_pop_front;
         cell_ctrl[i].load       = do_push_rear && (count_ff == CNT_W'(i));
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      if (g == 0) begin : g_first
         assign front_word = req_value;
      end else begin : g_mid
         assign front_word = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign rear_word = cell_word[g];
      end else begin : g_inner
         assign rear_word = cell_word[g+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .front_word (front_word),
         .rear_word  (rear_word),
         .value      (req_value),
         .word       (cell_word[g])
      );
   end

   // The rear entry sits in the cell just below the count.
   always_comb begin
      rear_tap = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) rear_tap = rear_tap | cell_word[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_push_front || do_push_rear) count_in = count_ff + 1'b1;
      else if (do_pop_front || do_pop_rear) count_in = count_ff - 1'b1;
   end

   always_comb begin
      rsp_data_in = '0;
      if (do_pop_front)     rsp_data_in = cell_word[0];
      else if (do_pop_rear) rsp_data_in = rear_tap;
   end

   assign count_ext = EXT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= count_ext[FILL_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_fill   = rsp_fill_ff;

endmodule

[dv/double_ended_queue_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_core: every accepted beat is run through
// a behavioral deque and each result strobe is compared against the predicted reply.
// Depends on deq_pkg and the double_ended_queue_core RTL.

module double_ended_queue_core_tb;
   import deq_pkg::*;

   typedef struct {
      kind_type                 kind;
      logic signed [WORD_W-1:0] value;
   } deq_op_type;

   typedef struct {
      logic signed [WORD_W-1:0] data;
      status_type               status;
      logic [FILL_W-1:0]        fill;
   } deq_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_kind = KIND_PUSH_FRONT;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_data;
   logic [1:0]               rsp_status;
   logic [FILL_W-1:0]        rsp_fill;

   deq_op_type    pending_ops[$];
   deq_reply_type predicted_replies[$];
   int            ops_queued = 0;
   int            ops_accepted = 0;
   int            fail_count = 0;
   bit            idling_on = 1'b1;

   // Behavioral copy of the deque contents.
   logic signed [WORD_W-1:0] deq_words[DEQ_DEPTH];
   int                       front_slot = 0;
   int                       fill_count = 0;

   double_ended_queue_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_fill   (rsp_fill)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic deq_reply_type deque_apply(kind_type kind,
                                                 logic signed [WORD_W-1:0] value);
      deq_reply_type reply;
      int            slot;
      reply.data   = '0;
      reply.status = ST_OK;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
            if (fill_count >= DEQ_DEPTH) begin
               reply.status = ST_OVERFLOW;
            end else begin
               if (kind == KIND_PUSH_FRONT) begin
                  front_slot = (front_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
                  slot = front_slot;
               end else begin
                  slot = (front_slot + fill_count) % DEQ_DEPTH;
               end
               deq_words[slot] = value;
               fill_count++;
            end
         end
         KIND_POP_FRONT: begin
            if (fill_count == 0) begin
               reply.status = ST_UNDERFLOW;
            end else begin
               reply.data = deq_words[front_slot];
               front_slot = (front_slot + 1) % DEQ_DEPTH;
               fill_count--;
            end
         end
         default: begin
            if (fill_count == 0) begin
               reply.status = ST_UNDERFLOW;
            end else begin
               reply.data = deq_words[(front_slot + fill_count - 1) % DEQ_DEPTH];
               fill_count--;
            end
         end
      endcase
      reply.fill = fill_count[FILL_W-1:0];
      return reply;
   endfunction

   task automatic queue_op(kind_type kind, logic signed [WORD_W-1:0] value);
      deq_op_type op;
      op.kind  = kind;
      op.value = value;
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Runs of pushes and pops with a bias that changes per run, so the deque
   // repeatedly fills to overflow and drains to underflow.
   task automatic queue_random_ops(int count);
      int push_pct;
      int run_left;
      bit is_push;
      bit at_front;
      push_pct = 50;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 15);
            case ($urandom_range(2))
               0: push_pct = 20;
               1: push_pct = 50;
               default: push_pct = 80;
            endcase
         end
         run_left--;
         is_push  = $urandom_range(99) < push_pct;
         at_front = 1'($urandom_range(1));
         if (is_push) begin
            queue_op(at_front ? KIND_PUSH_FRONT : KIND_PUSH_REAR, random_word());
         end else begin
            queue_op(at_front ? KIND_POP_FRONT : KIND_POP_REAR, random_word());
         end
      end
   endtask

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Driver: a beat is accepted at the edge where start is high and busy low.
   always @(posedge clock) begin : driver
      deq_op_type op;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start === 1'b1 && busy === 1'b0) begin
            predicted_replies.push_back(deque_apply(kind_type'(req_kind), req_value));
            ops_accepted++;
         end
         if (start === 1'b1 && busy !== 1'b0) begin
            // Hold the current beat until it is taken.
         end else if (pending_ops.size() != 0 && !(idling_on && $urandom_range(99) < 16)) begin
            op = pending_ops.pop_front();
            start     <= 1'b1;
            req_kind  <= op.kind;
            req_value <= op.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobe is checked against the oldest predicted reply.
   always @(posedge clock) begin : monitor
      deq_reply_type want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            note_failure("rsp_valid is unknown");
         end else if (rsp_valid) begin
            if (predicted_replies.size() == 0) begin
               note_failure($sformatf("unexpected result data=%h status=%0d fill=%0d",
                                      rsp_data, rsp_status, rsp_fill));
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_data !== want.data || rsp_status !== want.status ||
                   rsp_fill !== want.fill) begin
                  note_failure($sformatf({"mismatch: expected data=%h status=%0d fill=%0d,",
                                          " got data=%h status=%0d fill=%0d"},
                                         want.data, want.status, want.fill,
                                         rsp_data, rsp_status, rsp_fill));
               end
            end
         end
      end
   end

   task automatic wait_all_accepted();
      while (ops_accepted != ops_queued) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Underflow on an empty deque from both ends.
      queue_op(KIND_POP_FRONT, 32'sh7fff_ffff);
      queue_op(KIND_POP_REAR, 32'sh8000_0000);
      // Fill to capacity, starting with extreme words; the first front push wraps the head.
      queue_op(KIND_PUSH_FRONT, 32'sh8000_0000);
      queue_op(KIND_PUSH_REAR, 32'sh7fff_ffff);
      queue_op(KIND_PUSH_FRONT, '0);
      queue_op(KIND_PUSH_REAR, -1);
      queue_op(KIND_PUSH_FRONT, 32'sh5555_5555);
      queue_op(KIND_PUSH_REAR, 32'shaaaa_aaaa);
      for (int i = 0; i < 10; i++) begin
         queue_op(i % 2 ? KIND_PUSH_REAR : KIND_PUSH_FRONT, $urandom);
      end
      // A full deque must refuse pushes at either end.
      queue_op(KIND_PUSH_FRONT, 32'sh1234_5678);
      queue_op(KIND_PUSH_REAR, -1);
      queue_op(KIND_POP_FRONT, '0);
      queue_op(KIND_POP_REAR, '0);

      queue_random_ops(400);
      wait_all_accepted();
      // The sender stays quiet until every reply is back.
      wait_drained();

      idling_on = 1'b0;
      queue_random_ops(400);
      while (ops_accepted < ops_queued - 200) @(posedge clock);
      idling_on = 1'b1;
      wait_all_accepted();
      wait_drained();

      if (fail_count == 0) begin
         $display("double_ended_queue_core_tb passed");
      end else begin
         $display("double_ended_queue_core_tb failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("double_ended_queue_core_tb failed");
      $finish;
   end

endmodule
